FILE: hdl/bcmp_pkg.sv
// Shared types and constants for the barometric temperature/pressure compensation.
// Used by every bcmp_* module but bcmp_fifo; no dependencies.
`default_nettype none
package bcmp_pkg;

  localparam int unsigned RAW_W   = 20;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned PRESS_W = 24;
  localparam int unsigned CALW    = 16;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9    = 2'd3;

  localparam logic [20:0] PRESS_BASE   = 21'd1048576;
  localparam logic [33:0] TFINE_OFFSET = 34'd128000;
  localparam logic [43:0] DIV_SCALE    = 44'd3125;
  localparam logic [39:0] TEMP_ROUND   = 40'd128;
  localparam logic [63:0] V1_BIAS      = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [CALW-1:0] t1;
    logic [CALW-1:0] t2;
    logic [CALW-1:0] t3;
    logic [CALW-1:0] p1;
    logic [CALW-1:0] p2;
    logic [CALW-1:0] p3;
    logic [CALW-1:0] p4;
    logic [CALW-1:0] p5;
    logic [CALW-1:0] p6;
    logic [CALW-1:0] p7;
    logic [CALW-1:0] p8;
    logic [CALW-1:0] p9;
  } calib_t;

  // word between front and back: temperature done, pressure ready to divide
  typedef struct packed {
    logic [TEMP_W-1:0] tcs;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } mid_t;

  typedef struct packed {
    logic [TEMP_W-1:0] tcs;
    logic              fault;
  } tag_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  tcs;
    logic [PRESS_W-1:0] pa;
    logic               fault;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/bcmp_fifo.sv
// Small register queue with full/empty flags.
// Generic; no package dependency.
`default_nettype none
module bcmp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/bcmp_front.sv
// Front pipeline: fine temperature, centi temperature, pressure polynomial,
// dividend and divisor. Depends on bcmp_pkg.
`default_nettype none
module bcmp_front import bcmp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [RAW_W-1:0] at,
  input  wire logic [RAW_W-1:0] ap,
  input  wire calib_t           cal,
  output logic                  out_valid,
  output mid_t                  out
);
  localparam int unsigned NST = 10;

  logic [NST:1] vld;

  // stage 1
  logic [31:0] a, b, t2x, t3x;
  logic [31:0] s1_ma, s1_bb;
  logic [20:0] s1_p;
  // stage 2
  logic [31:0] bb_sh;
  logic [31:0] s2_tv1, s2_u;
  logic [20:0] s2_p;
  // stage 3
  logic [31:0] s3_tf;
  logic [20:0] s3_p;
  // stage 4
  logic signed [39:0] tf5, tc;
  logic [15:0] tcs;
  logic [15:0] s4_tcs;
  logic [33:0] s4_v1;
  logic [20:0] s4_p;
  // stage 5
  logic signed [67:0] sq_full;
  logic signed [49:0] m5, m2;
  logic [63:0] s5_sq;
  logic [49:0] s5_m5, s5_m2;
  logic [15:0] s5_tcs;
  logic [20:0] s5_p;
  // stage 6
  logic [31:0] p6x, p3x;
  logic signed [48:0] a6l, a3l;
  logic [48:0] s6_a6l, s6_a3l;
  logic [31:0] s6_a6h, s6_a3h;
  logic [49:0] s6_m5, s6_m2;
  logic [15:0] s6_tcs;
  logic [20:0] s6_p;
  // stage 7
  logic [63:0] x6, x3, v2, w;
  logic [63:0] s7_v2, s7_w;
  logic [15:0] s7_tcs;
  logic [20:0] s7_p;
  // stage 8
  logic [63:0] y, n0;
  logic [47:0] s8_yl;
  logic [31:0] s8_yh;
  logic [63:0] s8_n0;
  logic [15:0] s8_tcs;
  // stage 9
  logic [63:0] dsum, d;
  logic [63:0] s9_d;
  logic [43:0] s9_nl;
  logic [31:0] s9_nh;
  logic [15:0] s9_tcs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], in_valid};
    end
  end

  assign t2x = {{16{cal.t2[15]}}, cal.t2};
  assign t3x = {{16{cal.t3[15]}}, cal.t3};
  assign a   = {15'b0, at[19:3]} - {15'b0, cal.t1, 1'b0};
  assign b   = {16'b0, at[19:4]} - {16'b0, cal.t1};

  assign bb_sh = 32'($signed(s1_bb) >>> 11'd12);

  assign tf5 = $signed({{8{s3_tf[31]}}, s3_tf}) * 40'sd5 + $signed(TEMP_ROUND);
  assign tc  = tf5 >>> 8;
  always_comb begin
    if (tc < -40'sd32768) begin
      tcs = 16'h8000;
    end else if (tc > 40'sd32767) begin
      tcs = 16'h7FFF;
    end else begin
      tcs = tc[15:0];
    end
  end

  assign sq_full = $signed(s4_v1) * $signed(s4_v1);
  assign m5      = $signed(s4_v1) * $signed(cal.p5);
  assign m2      = $signed(s4_v1) * $signed(cal.p2);

  assign p6x = {{16{cal.p6[15]}}, cal.p6};
  assign p3x = {{16{cal.p3[15]}}, cal.p3};
  assign a6l = $signed({1'b0, s5_sq[31:0]}) * $signed(cal.p6);
  assign a3l = $signed({1'b0, s5_sq[31:0]}) * $signed(cal.p3);

  assign x6 = {{15{s6_a6l[48]}}, s6_a6l} + {s6_a6h, 32'b0};
  assign x3 = {{15{s6_a3l[48]}}, s6_a3l} + {s6_a3h, 32'b0};
  assign v2 = x6 + ({{14{s6_m5[49]}}, s6_m5} << 17) + ({{48{cal.p4[15]}}, cal.p4} << 35);
  assign w  = 64'($signed(x3) >>> 8) + ({{14{s6_m2[49]}}, s6_m2} << 12);

  assign y  = s7_w + V1_BIAS;
  assign n0 = ({43'b0, s7_p} << 31) - s7_v2;

  assign dsum = {16'b0, s8_yl} + {s8_yh, 32'b0};
  assign d    = 64'($signed(dsum) >>> 33);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ma  <= a * t2x;
      s1_bb  <= b * b;
      s1_p   <= PRESS_BASE - {1'b0, ap};

      s2_tv1 <= 32'($signed(s1_ma) >>> 11);
      s2_u   <= bb_sh * t3x;
      s2_p   <= s1_p;

      s3_tf  <= s2_tv1 + 32'($signed(s2_u) >>> 14);
      s3_p   <= s2_p;

      s4_tcs <= tcs;
      s4_v1  <= {{2{s3_tf[31]}}, s3_tf} - TFINE_OFFSET;
      s4_p   <= s3_p;

      s5_sq  <= sq_full[63:0];
      s5_m5  <= m5;
      s5_m2  <= m2;
      s5_tcs <= s4_tcs;
      s5_p   <= s4_p;

      s6_a6l <= a6l;
      s6_a3l <= a3l;
      s6_a6h <= s5_sq[63:32] * p6x;
      s6_a3h <= s5_sq[63:32] * p3x;
      s6_m5  <= s5_m5;
      s6_m2  <= s5_m2;
      s6_tcs <= s5_tcs;
      s6_p   <= s5_p;

      s7_v2  <= v2;
      s7_w   <= w;
      s7_tcs <= s6_tcs;
      s7_p   <= s6_p;

      s8_yl  <= {16'b0, y[31:0]} * {32'b0, cal.p1};
      s8_yh  <= y[63:32] * {16'b0, cal.p1};
      s8_n0  <= n0;
      s8_tcs <= s7_tcs;

      s9_d   <= d;
      s9_nl  <= {12'b0, s8_n0[31:0]} * DIV_SCALE;
      s9_nh  <= s8_n0[63:32] * DIV_SCALE[31:0];
      s9_tcs <= s8_tcs;

      out.num <= {20'b0, s9_nl} + {s9_nh, 32'b0};
      out.den <= s9_d;
      out.tcs <= s9_tcs;
    end
  end

  assign out_valid = vld[NST];
endmodule
`default_nettype wire

FILE: hdl/bcmp_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Carries a tag alongside each word. Depends on bcmp_pkg.
`default_nettype none
module bcmp_div import bcmp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [WORD_W-1:0] num,
  input  wire logic [WORD_W-1:0] den,
  input  wire tag_t              in_tag,
  output logic                   out_valid,
  output logic [WORD_W-1:0]      quot,
  output tag_t                   out_tag
);
  localparam int unsigned NB = WORD_W;

  logic [NB-1:0] rem  [0:NB];
  logic [NB-1:0] nq   [0:NB];
  logic [NB-1:0] dv   [0:NB];
  logic          ng   [0:NB];
  tag_t          tg   [0:NB];
  logic [NB+1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NB:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      nq[0]  <= num[NB-1] ? (~num + 1'b1) : num;
      dv[0]  <= den[NB-1] ? (~den + 1'b1) : den;
      ng[0]  <= num[NB-1] ^ den[NB-1];
      tg[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [NB:0] rs;
    logic [NB:0] diff;
    logic        ge;
    assign rs   = {rem[k], nq[k][NB-1]};
    assign diff = rs - {1'b0, dv[k]};
    assign ge   = !diff[NB];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[NB-1:0] : rs[NB-1:0];
        nq[k+1]  <= {nq[k][NB-2:0], ge};
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot    <= ng[NB] ? (~nq[NB] + 1'b1) : nq[NB];
      out_tag <= tg[NB];
    end
  end

  assign out_valid = vld[NB+1];
endmodule
`default_nettype wire

FILE: hdl/bcmp_back.sv
// Back pipeline: divide, quadratic correction with P7..P9, saturation.
// Depends on bcmp_pkg and bcmp_div.
`default_nettype none
module bcmp_back import bcmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire mid_t in,
  input  wire calib_t cal,
  output logic      out_valid,
  output res_t      out
);
  tag_t        din_tag, dq_tag;
  logic        dq_valid;
  logic [63:0] dq;

  // stage A
  logic [63:0] ps;
  logic [31:0] p8x, p9x;
  logic signed [48:0] pl8;
  logic [63:0] sa_ll, sa_p;
  logic [31:0] sa_hl, sa_ph8;
  logic [48:0] sa_pl8;
  tag_t        sa_tag;
  // stage B
  logic [63:0] x, w2sum;
  logic [63:0] sb_x, sb_w2, sb_p;
  tag_t        sb_tag;
  // stage C
  logic signed [48:0] xl9;
  logic [48:0] sc_xl9;
  logic [31:0] sc_xh9;
  logic [63:0] sc_w2, sc_p;
  tag_t        sc_tag;
  // stage D
  logic [63:0] w1sum, w1;
  logic [63:0] sd_s;
  tag_t        sd_tag;
  // stage E
  logic [63:0] pf;
  logic [23:0] pa;

  logic [4:0] vld;

  assign din_tag.tcs   = in.tcs;
  assign din_tag.fault = (in.den == '0);

  bcmp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .num       (in.num),
    .den       (in.den),
    .in_tag    (din_tag),
    .out_valid (dq_valid),
    .quot      (dq),
    .out_tag   (dq_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], dq_valid};
    end
  end

  assign ps  = 64'($signed(dq) >>> 13);
  assign p8x = {{16{cal.p8[15]}}, cal.p8};
  assign p9x = {{16{cal.p9[15]}}, cal.p9};
  assign pl8 = $signed({1'b0, dq[31:0]}) * $signed(cal.p8);

  // square mod 2^64: low*low plus twice the cross term shifted up
  assign x     = sa_ll + {sa_hl[30:0], 1'b0, 32'b0};
  assign w2sum = {{15{sa_pl8[48]}}, sa_pl8} + {sa_ph8, 32'b0};

  assign xl9 = $signed({1'b0, sb_x[31:0]}) * $signed(cal.p9);

  assign w1sum = {{15{sc_xl9[48]}}, sc_xl9} + {sc_xh9, 32'b0};
  assign w1    = 64'($signed(w1sum) >>> 25);

  assign pf = 64'($signed(sd_s) >>> 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);
  always_comb begin
    if (sd_tag.fault || pf[63]) begin
      pa = '0;
    end else if (pf[63:32] != '0) begin
      pa = 24'hFF_FFFF;
    end else begin
      pa = pf[31:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_ll  <= {32'b0, ps[31:0]} * {32'b0, ps[31:0]};
      sa_hl  <= ps[63:32] * ps[31:0];
      sa_pl8 <= pl8;
      sa_ph8 <= dq[63:32] * p8x;
      sa_p   <= dq;
      sa_tag <= dq_tag;

      sb_x   <= x;
      sb_w2  <= 64'($signed(w2sum) >>> 19);
      sb_p   <= sa_p;
      sb_tag <= sa_tag;

      sc_xl9 <= xl9;
      sc_xh9 <= sb_x[63:32] * p9x;
      sc_w2  <= sb_w2;
      sc_p   <= sb_p;
      sc_tag <= sb_tag;

      sd_s   <= sc_p + w1 + sc_w2;
      sd_tag <= sc_tag;

      out.tcs   <= sd_tag.tcs;
      out.pa    <= pa;
      out.fault <= sd_tag.fault;
    end
  end

  assign out_valid = vld[4];
endmodule
`default_nettype wire

FILE: hdl/baro_temp_pressure_compensate.sv
// Top level: calibration registers, front pipeline, middle queue, back
// pipeline and result queue. Depends on bcmp_pkg and all bcmp_* modules.
//
//   channel   direction  handshake            words
//   input     in         push / full          raw_temperature, raw_pressure
//   result    out        pop / empty          temperature_centi, pressure_pa, divide_fault
//   config    in         cfg_write (no wait)  cfg_index, cfg_data
//
// One sample pair is taken per cycle while full is low. A sample passes through
// the front pipeline, middle queue, bit-per-stage divider, correction stages
// and result queue. Each pipeline holds in place when its last word is valid
// and the queue after it is full, so the two sides stall independently. Reset
// clears the queues, pipeline valids and calibration registers.
`default_nettype none
module baro_temp_pressure_compensate import bcmp_pkg::*; #(
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [RAW_W-1:0]     raw_temperature,
  input  wire logic [RAW_W-1:0]     raw_pressure,
  input  wire logic                 pop,
  output logic                      empty,
  output logic signed [TEMP_W-1:0]  temperature_centi,
  output logic [PRESS_W-1:0]        pressure_pa,
  output logic                      divide_fault,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);
  localparam int unsigned MID_W = $bits(mid_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_p9;
  calib_t      cal;

  logic front_en, front_valid;
  mid_t front_out;
  logic mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0] mid_q;
  logic back_en, back_valid;
  res_t back_out;
  logic out_full;
  logic [RES_W-1:0] out_q;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_p9   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_calib       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_calib_low  <= cfg_data;
        REG_PRESS_HIGH: press_calib_high <= cfg_data;
        REG_PRESS_P9:   press_calib_p9   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cal.t1 = temp_calib[15:0];
  assign cal.t2 = temp_calib[31:16];
  assign cal.t3 = temp_calib[47:32];
  assign cal.p1 = press_calib_low[15:0];
  assign cal.p2 = press_calib_low[31:16];
  assign cal.p3 = press_calib_low[47:32];
  assign cal.p4 = press_calib_low[63:48];
  assign cal.p5 = press_calib_high[15:0];
  assign cal.p6 = press_calib_high[31:16];
  assign cal.p7 = press_calib_high[47:32];
  assign cal.p8 = press_calib_high[63:48];
  assign cal.p9 = press_calib_p9;

  // hold the front pipeline while its last word cannot enter the queue
  assign front_en = !(front_valid && mid_full);
  assign full     = !front_en;

  bcmp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .in_valid  (push && front_en),
    .at        (raw_temperature),
    .ap        (raw_pressure),
    .cal       (cal),
    .out_valid (front_valid),
    .out       (front_out)
  );

  bcmp_fifo #(.W(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_out),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_q),
    .empty (mid_empty)
  );

  assign back_en = !(back_valid && out_full);
  assign mid_pop = back_en && !mid_empty;

  bcmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (mid_pop),
    .in        (mid_t'(mid_q)),
    .cal       (cal),
    .out_valid (back_valid),
    .out       (back_out)
  );

  bcmp_fifo #(.W(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .din   (back_out),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_q),
    .empty (empty)
  );

  assign res               = res_t'(out_q);
  assign temperature_centi = res.tcs;
  assign pressure_pa       = res.pa;
  assign divide_fault      = res.fault;
endmodule
`default_nettype wire
